// ----- sv/plai_pkg.sv -----
package plai_pkg;

	localparam int LEN_BITS  = 28;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
	localparam int FRAC_BITS = 16;
	localparam int SQ_BITS   = 2 * LEN_BITS + 2;
	localparam int ROOT_BITS = SQ_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 3;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_REVERSE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_APP_RD, S_SQ_X, S_SQ_Y, S_SQRT, S_SEGEND,
		S_REV_A, S_REV_B, S_REV_C, S_REV_D, S_RB_START, S_RB_P, S_RB_C,
		S_Q_SCAN, S_Q_DIV, S_Q_PA, S_Q_PB, S_Q_PC, S_Q_MUL, S_Q_ADD,
		S_Q_LAST, S_Q_LASTCAP, S_EMIT
	} state_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_ctl_t;

endpackage

// ----- sv/plai_ram.sv -----
module plai_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/plai_front.sv -----
// Accepts requests, decodes the operation and queues them for the back end.
module plai_front #(
	parameter int PW = 60
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          opcode,
	input  logic [PW-1:0]       pt_in,
	input  logic [27:0]         pos_in,
	output plai_pkg::cmd_ctl_t  cmd_ctl,
	output logic [PW-1:0]       cmd_pt,
	output logic [27:0]         cmd_pos,
	input  logic                cmd_pop
);

	plai_pkg::op_t   op_q  [2];
	logic [PW-1:0]   pt_q  [2];
	logic [27:0]     pos_q [2];
	logic            wptr_q, rptr_q;
	logic [1:0]      cnt_q;
	plai_pkg::op_t   op_dec;
	logic            do_push, do_pop;

	always_comb begin
		case (opcode)
			plai_pkg::OP_CLEAR:   op_dec = plai_pkg::OP_CLEAR;
			plai_pkg::OP_APPEND:  op_dec = plai_pkg::OP_APPEND;
			plai_pkg::OP_REVERSE: op_dec = plai_pkg::OP_REVERSE;
			default:              op_dec = plai_pkg::OP_QUERY;
		endcase
	end

	assign full          = (cnt_q == 2'd2);
	assign do_push       = push && !full;
	assign do_pop        = cmd_pop && (cnt_q != 2'd0);
	assign cmd_ctl.valid = (cnt_q != 2'd0);
	assign cmd_ctl.op    = op_q[rptr_q];
	assign cmd_pt        = pt_q[rptr_q];
	assign cmd_pos       = pos_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			op_q[wptr_q]  <= op_dec;
			pt_q[wptr_q]  <= pt_in;
			pos_q[wptr_q] <= pos_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- sv/plai_back.sv -----
// Sequencer that carries out one operation at a time on the stored path.
module plai_back #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plai_pkg::cmd_ctl_t               cmd_ctl,
	input  logic [3*COORD_BITS-1:0]          cmd_pt,
	input  logic [27:0]                      cmd_pos,
	output logic                             cmd_pop,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [COORD_BITS-1:0]     out_x,
	output logic signed [COORD_BITS-1:0]     out_y,
	output logic signed [COORD_BITS-1:0]     out_z,
	output logic [27:0]                      total_length,
	output logic [$clog2(MAX_POINTS+1)-1:0]  point_count,
	output logic [1:0]                       status
);

	localparam int CB = COORD_BITS;
	localparam int PW = 3 * CB;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LB = plai_pkg::LEN_BITS;
	localparam int FB = plai_pkg::FRAC_BITS;
	localparam int SB = plai_pkg::SQ_BITS;
	localparam int RB = plai_pkg::ROOT_BITS;
	localparam int MB = plai_pkg::REM_BITS;
	localparam int PRB = CB + FB + 2;

	plai_pkg::state_t state_q, state_d;
	plai_pkg::op_t    op_q;
	logic [CW-1:0]    count_q, idx_q;
	logic [LB-1:0]    total_q, acc_q, pos_q, len_q, drem_q;
	logic [AW-1:0]    lo_q, hi_q;
	logic [PW-1:0]    cmdpt_q, prev_q, cur_q, tmp_q, pa_q, pb_q;
	logic [SB-1:0]    sq_q;
	logic [MB-1:0]    rem_q;
	logic [RB-1:0]    root_q;
	logic [4:0]       step_q;
	logic             sat_q;
	logic [FB-1:0]    frac_q;
	logic signed [PRB-1:0] prod_q [3];
	logic [CB-1:0]    res_q [3];
	plai_pkg::status_t res_st_q;
	logic             outv_q;

	// RAM ports
	logic          pt_we, cum_we;
	logic [AW-1:0] pt_waddr, pt_raddr, cum_waddr, cum_raddr;
	logic [PW-1:0] pt_wdata, pt_rd;
	logic [LB-1:0] cum_wdata, cum_rd;

	plai_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rd)
	);

	plai_ram #(.WIDTH(LB), .DEPTH(MAX_POINTS)) u_cum_ram (
		.clk(clk), .we(cum_we), .waddr(cum_waddr), .wdata(cum_wdata),
		.raddr(cum_raddr), .rdata(cum_rd)
	);

	// Segment length datapath
	logic signed [CB:0] dx, dy;
	logic [CB:0]        mx, my;
	logic [LB-1:0]      mul_a;
	logic [2*LB-1:0]    sq_prod;
	logic               mag_sat;
	logic [MB-1:0]      rem_n, trial;
	logic [LB-1:0]      seg_len;
	logic [LB:0]        seg_sum;
	logic [LB-1:0]      seg_acc;
	logic [LB:0]        div_r2;
	logic               load_out;

	always_comb begin
		dx = {cur_q[PW-1], cur_q[PW-1:2*CB]} - {prev_q[PW-1], prev_q[PW-1:2*CB]};
		dy = {cur_q[2*CB-1], cur_q[2*CB-1:CB]} - {prev_q[2*CB-1], prev_q[2*CB-1:CB]};
		mx = dx[CB] ? -dx : dx;
		my = dy[CB] ? -dy : dy;
		mag_sat = (64'(mx) > 64'(plai_pkg::LEN_MAX)) || (64'(my) > 64'(plai_pkg::LEN_MAX));
		mul_a   = (state_q == plai_pkg::S_SQ_X) ? LB'(mx) : LB'(my);
		sq_prod = mul_a * mul_a;
		rem_n   = {rem_q[MB-3:0], sq_q[SB-1:SB-2]};
		trial   = MB'({root_q, 2'b01});
		if (sat_q || (RB'(root_q) > RB'(plai_pkg::LEN_MAX))) begin
			seg_len = plai_pkg::LEN_MAX;
		end else begin
			seg_len = root_q[LB-1:0];
		end
		seg_sum = {1'b0, acc_q} + {1'b0, seg_len};
		seg_acc = seg_sum[LB] ? plai_pkg::LEN_MAX : seg_sum[LB-1:0];
		div_r2  = {drem_q, 1'b0};
	end

	assign load_out = !outv_q || pop;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		pt_we     = 1'b0;
		cum_we    = 1'b0;
		pt_waddr  = lo_q;
		pt_wdata  = pt_rd;
		cum_waddr = AW'(idx_q);
		cum_wdata = seg_acc;
		pt_raddr  = AW'(idx_q);
		cum_raddr = AW'(idx_q + CW'(2));
		case (state_q)
			plai_pkg::S_IDLE: begin
				if (cmd_ctl.valid) begin
					cmd_pop = 1'b1;
					state_d = plai_pkg::S_DECODE;
				end
			end
			plai_pkg::S_DECODE: begin
				case (op_q)
					plai_pkg::OP_CLEAR: state_d = plai_pkg::S_EMIT;
					plai_pkg::OP_APPEND: begin
						if (count_q >= CW'(MAX_POINTS)) begin
							state_d = plai_pkg::S_EMIT;
						end else if (count_q == '0) begin
							pt_we     = 1'b1;
							pt_waddr  = '0;
							pt_wdata  = cmdpt_q;
							cum_we    = 1'b1;
							cum_waddr = '0;
							cum_wdata = '0;
							state_d   = plai_pkg::S_EMIT;
						end else begin
							pt_raddr = AW'(count_q - CW'(1));
							state_d  = plai_pkg::S_APP_RD;
						end
					end
					plai_pkg::OP_REVERSE: begin
						state_d = (count_q < CW'(2)) ? plai_pkg::S_EMIT : plai_pkg::S_REV_A;
					end
					default: begin
						cum_raddr = AW'(1);
						if (count_q == '0) begin
							state_d = plai_pkg::S_EMIT;
						end else if (count_q == CW'(1)) begin
							state_d = plai_pkg::S_Q_LAST;
						end else begin
							state_d = plai_pkg::S_Q_SCAN;
						end
					end
				endcase
			end
			plai_pkg::S_APP_RD: state_d = plai_pkg::S_SQ_X;
			plai_pkg::S_SQ_X:   state_d = plai_pkg::S_SQ_Y;
			plai_pkg::S_SQ_Y:   state_d = sat_q ? plai_pkg::S_SEGEND : plai_pkg::S_SQRT;
			plai_pkg::S_SQRT: begin
				if (step_q == 5'(RB - 1)) begin
					state_d = plai_pkg::S_SEGEND;
				end
			end
			plai_pkg::S_SEGEND: begin
				cum_we = 1'b1;
				if (op_q == plai_pkg::OP_APPEND) begin
					pt_we     = 1'b1;
					pt_waddr  = AW'(count_q);
					pt_wdata  = cur_q;
					cum_waddr = AW'(count_q);
					state_d   = plai_pkg::S_EMIT;
				end else begin
					pt_raddr = AW'(idx_q + CW'(1));
					state_d  = (idx_q == count_q - CW'(1)) ? plai_pkg::S_EMIT
					                                       : plai_pkg::S_RB_C;
				end
			end
			plai_pkg::S_REV_A: begin
				pt_raddr = lo_q;
				state_d  = plai_pkg::S_REV_B;
			end
			plai_pkg::S_REV_B: begin
				pt_raddr = hi_q;
				state_d  = plai_pkg::S_REV_C;
			end
			plai_pkg::S_REV_C: begin
				pt_we    = 1'b1;
				pt_waddr = lo_q;
				pt_wdata = pt_rd;
				state_d  = plai_pkg::S_REV_D;
			end
			plai_pkg::S_REV_D: begin
				pt_we    = 1'b1;
				pt_waddr = hi_q;
				pt_wdata = tmp_q;
				state_d  = ((lo_q + AW'(1)) < (hi_q - AW'(1))) ? plai_pkg::S_REV_A
				                                              : plai_pkg::S_RB_START;
			end
			plai_pkg::S_RB_START: begin
				pt_raddr  = '0;
				cum_we    = 1'b1;
				cum_waddr = '0;
				cum_wdata = '0;
				state_d   = plai_pkg::S_RB_P;
			end
			plai_pkg::S_RB_P: begin
				pt_raddr = AW'(idx_q);
				state_d  = plai_pkg::S_RB_C;
			end
			plai_pkg::S_RB_C: state_d = plai_pkg::S_SQ_X;
			plai_pkg::S_Q_SCAN: begin
				if (cum_rd > pos_q) begin
					state_d = plai_pkg::S_Q_DIV;
				end else if ((idx_q + CW'(2)) < count_q) begin
					state_d = plai_pkg::S_Q_SCAN;
				end else begin
					state_d = plai_pkg::S_Q_LAST;
				end
			end
			plai_pkg::S_Q_DIV: begin
				if (step_q == 5'(FB - 1)) begin
					state_d = plai_pkg::S_Q_PA;
				end
			end
			plai_pkg::S_Q_PA: begin
				pt_raddr = AW'(idx_q);
				state_d  = plai_pkg::S_Q_PB;
			end
			plai_pkg::S_Q_PB: begin
				pt_raddr = AW'(idx_q + CW'(1));
				state_d  = plai_pkg::S_Q_PC;
			end
			plai_pkg::S_Q_PC:  state_d = plai_pkg::S_Q_MUL;
			plai_pkg::S_Q_MUL: state_d = plai_pkg::S_Q_ADD;
			plai_pkg::S_Q_ADD: state_d = plai_pkg::S_EMIT;
			plai_pkg::S_Q_LAST: begin
				pt_raddr = AW'(count_q - CW'(1));
				state_d  = plai_pkg::S_Q_LASTCAP;
			end
			plai_pkg::S_Q_LASTCAP: state_d = plai_pkg::S_EMIT;
			plai_pkg::S_EMIT: begin
				if (load_out) begin
					state_d = plai_pkg::S_IDLE;
				end
			end
			default: state_d = plai_pkg::S_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			plai_pkg::S_IDLE: begin
				op_q    <= cmd_ctl.op;
				cmdpt_q <= cmd_pt;
				pos_q   <= cmd_pos;
			end
			plai_pkg::S_DECODE: begin
				for (int k = 0; k < 3; k++) begin
					res_q[k] <= '0;
				end
				res_st_q <= plai_pkg::ST_OK;
				acc_q    <= (op_q == plai_pkg::OP_APPEND) ? total_q : '0;
				lo_q     <= '0;
				hi_q     <= AW'(count_q - CW'(1));
				if (op_q == plai_pkg::OP_APPEND && count_q >= CW'(MAX_POINTS)) begin
					res_st_q <= plai_pkg::ST_FULL;
				end
				if (op_q == plai_pkg::OP_QUERY && count_q == '0) begin
					res_st_q <= plai_pkg::ST_EMPTY;
				end
			end
			plai_pkg::S_APP_RD: begin
				prev_q <= pt_rd;
				cur_q  <= cmdpt_q;
			end
			plai_pkg::S_SQ_X: begin
				sq_q  <= SB'(sq_prod);
				sat_q <= mag_sat;
			end
			plai_pkg::S_SQ_Y: begin
				sq_q   <= sq_q + SB'(sq_prod);
				rem_q  <= '0;
				root_q <= '0;
			end
			plai_pkg::S_SQRT: begin
				sq_q <= {sq_q[SB-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[RB-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[RB-2:0], 1'b0};
				end
			end
			plai_pkg::S_SEGEND: begin
				acc_q  <= seg_acc;
				prev_q <= cur_q;
			end
			plai_pkg::S_REV_B: tmp_q <= pt_rd;
			plai_pkg::S_REV_D: begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			plai_pkg::S_RB_START: acc_q <= '0;
			plai_pkg::S_RB_P:     prev_q <= pt_rd;
			plai_pkg::S_RB_C:     cur_q <= pt_rd;
			plai_pkg::S_Q_SCAN: begin
				if (cum_rd > pos_q) begin
					len_q  <= cum_rd - acc_q;
					drem_q <= pos_q - acc_q;
				end else begin
					acc_q <= cum_rd;
				end
			end
			plai_pkg::S_Q_DIV: begin
				if (div_r2 >= {1'b0, len_q}) begin
					drem_q <= LB'(div_r2 - {1'b0, len_q});
					frac_q <= {frac_q[FB-2:0], 1'b1};
				end else begin
					drem_q <= div_r2[LB-1:0];
					frac_q <= {frac_q[FB-2:0], 1'b0};
				end
			end
			plai_pkg::S_Q_PB: pa_q <= pt_rd;
			plai_pkg::S_Q_PC: pb_q <= pt_rd;
			plai_pkg::S_Q_MUL: begin
				for (int k = 0; k < 3; k++) begin
					prod_q[k] <= PRB'($signed({pb_q[k*CB+CB-1], pb_q[k*CB +: CB]})
					             - $signed({pa_q[k*CB+CB-1], pa_q[k*CB +: CB]}))
					             * PRB'($signed({1'b0, frac_q}));
				end
			end
			plai_pkg::S_Q_ADD: begin
				for (int k = 0; k < 3; k++) begin
					res_q[2-k] <= pa_q[k*CB +: CB] + prod_q[k][FB +: CB];
				end
			end
			plai_pkg::S_Q_LASTCAP: begin
				res_q[0] <= pt_rd[PW-1:2*CB];
				res_q[1] <= pt_rd[2*CB-1:CB];
				res_q[2] <= pt_rd[CB-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == plai_pkg::S_EMIT && load_out) begin
			out_x        <= res_q[0];
			out_y        <= res_q[1];
			out_z        <= res_q[2];
			total_length <= total_q;
			point_count  <= count_q;
			status       <= res_st_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plai_pkg::S_IDLE;
			count_q <= '0;
			total_q <= '0;
			idx_q   <= '0;
			step_q  <= '0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plai_pkg::S_EMIT && load_out) begin
				outv_q <= 1'b1;
			end else if (pop) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				plai_pkg::S_DECODE: begin
					idx_q <= '0;
					if (op_q == plai_pkg::OP_CLEAR) begin
						count_q <= '0;
						total_q <= '0;
					end else if (op_q == plai_pkg::OP_APPEND && count_q == '0) begin
						count_q <= CW'(1);
						total_q <= '0;
					end
				end
				plai_pkg::S_SQ_Y: step_q <= '0;
				plai_pkg::S_SQRT: step_q <= step_q + 5'd1;
				plai_pkg::S_SEGEND: begin
					if (op_q == plai_pkg::OP_APPEND) begin
						count_q <= count_q + CW'(1);
						total_q <= seg_acc;
					end else if (idx_q == count_q - CW'(1)) begin
						total_q <= seg_acc;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				plai_pkg::S_RB_START: idx_q <= CW'(1);
				plai_pkg::S_Q_SCAN: begin
					step_q <= '0;
					if (!(cum_rd > pos_q)) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				plai_pkg::S_Q_DIV: step_q <= step_q + 5'd1;
				default: begin
				end
			endcase
		end
	end

	assign empty = !outv_q;

endmodule

// ----- sv/polyline_arc_length_interpolator.sv -----
// Polyline arc-length interpolator. The block stores a path of up to MAX_POINTS
// points (signed Q16.4 x, y and z) and serves four requests: clear, append a
// point, reverse the point order, and query the point that lies a given planar
// distance (unsigned Q24.4) along the path. Every request yields exactly one
// result, which carries the interpolated point for a query (zero otherwise),
// the total planar path length, the number of stored points and a status:
// ok, query on an empty path, or append dropped because the path is full.
// Requests enter a two-entry queue, so a new request is taken while the
// sequencer behind it is busy, and one finished result is held in an output
// register until it is popped. Requests are carried out one at a time. An
// append gets its segment length from the square root unit, which produces
// one root bit per cycle. A query scans the stored cumulative lengths one per
// cycle through the single RAM read port, followed by a fraction divider and
// the interpolation multiplies. A reverse swaps the points through the point
// RAM and then rebuilds the cumulative lengths segment by segment.
module polyline_arc_length_interpolator #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       opcode,
	input  logic signed [COORD_BITS-1:0]     point_x,
	input  logic signed [COORD_BITS-1:0]     point_y,
	input  logic signed [COORD_BITS-1:0]     point_z,
	input  logic [27:0]                      query_position,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [COORD_BITS-1:0]     out_x,
	output logic signed [COORD_BITS-1:0]     out_y,
	output logic signed [COORD_BITS-1:0]     out_z,
	output logic [27:0]                      total_length,
	output logic [$clog2(MAX_POINTS+1)-1:0]  point_count,
	output logic [1:0]                       status
);

	localparam int PW = 3 * COORD_BITS;

	// Decoded request at the head of the queue.
	plai_pkg::cmd_ctl_t cmd_ctl;
	logic [PW-1:0]      cmd_pt;
	logic [27:0]        cmd_pos;
	logic               cmd_pop;

	// The front end takes requests and decodes the operation.
	plai_front #(.PW(PW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.opcode  (opcode),
		.pt_in   ({point_x, point_y, point_z}),
		.pos_in  (query_position),
		.cmd_ctl (cmd_ctl),
		.cmd_pt  (cmd_pt),
		.cmd_pos (cmd_pos),
		.cmd_pop (cmd_pop)
	);

	// The back end owns the path storage and carries out each request.
	plai_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_ctl      (cmd_ctl),
		.cmd_pt       (cmd_pt),
		.cmd_pos      (cmd_pos),
		.cmd_pop      (cmd_pop),
		.empty        (empty),
		.pop          (pop),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.total_length (total_length),
		.point_count  (point_count),
		.status       (status)
	);

endmodule

// ----- tb/sv/tb_polyline_arc_length_interpolator.sv -----
module tb_polyline_arc_length_interpolator;

	localparam int MAX_PTS = 64;
	localparam int CB      = 20;
	localparam logic [27:0] LEN_TOP = 28'hFFFFFFF;

	// Clock, reset and the ports of the block.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [1:0] opcode = plai_pkg::OP_CLEAR;
	logic signed [CB-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic [27:0] query_position = '0;
	logic signed [CB-1:0] out_x, out_y, out_z;
	logic [27:0] total_length;
	logic [6:0] point_count;
	logic [1:0] status;

	// One expected result, as the block should present it.
	typedef struct {
		logic signed [CB-1:0] x, y, z;
		logic [27:0] total;
		logic [6:0]  count;
		logic [1:0]  stat;
	} answer_t;

	answer_t pending_answers[$];

	// The path as the block should hold it.
	longint path_x[MAX_PTS], path_y[MAX_PTS], path_z[MAX_PTS];
	longint cum_len[MAX_PTS];
	int     num_points;
	longint path_len;

	int mismatches;
	int results_seen;
	// Idle percentages for both sides; zero gives a stretch with no gaps at all.
	int send_idle_pct = 36;
	int take_idle_pct = 36;
	// The result side holds off for this many cycles when asked to.
	int hold_off_cycles;

	polyline_arc_length_interpolator #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CB)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.query_position(query_position), .empty(empty), .pop(pop),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .total_length(total_length),
		.point_count(point_count), .status(status)
	);

	always #5 clk = ~clk;

	// Integer square root rounded down, worked bit by bit.
	function automatic longint floor_root(longint v);
		longint res, bit_w;
		res = 0;
		bit_w = 64'sd1 <<< 62;
		while (bit_w > v)
			bit_w = bit_w >>> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >>> 1) + bit_w;
			end else begin
				res = res >>> 1;
			end
			bit_w = bit_w >>> 2;
		end
		return res;
	endfunction

	// Planar length between stored points a and b, saturated to 28 bits.
	function automatic longint planar_length(int a, int b);
		longint dx, dy, r;
		dx = path_x[b] - path_x[a];
		dy = path_y[b] - path_y[a];
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		r = floor_root(dx * dx + dy * dy);
		return (r > LEN_TOP) ? LEN_TOP : r;
	endfunction

	// Linear blend with the step rounded towards minus infinity.
	function automatic longint blend(longint a, longint b, longint f);
		longint prod;
		prod = (b - a) * f;
		if (prod >= 0)
			return a + (prod >>> 16);
		return a - ((-prod + 65535) >>> 16);
	endfunction

	// Applies one request to the path and returns the result it should give.
	function automatic answer_t path_update(logic [1:0] op, logic signed [CB-1:0] px,
			logic signed [CB-1:0] py, logic signed [CB-1:0] pz, logic [27:0] pos);
		answer_t a;
		longint c, seg, f, acc, t;
		int i, lo, hi;
		bit found;
		a.x = '0; a.y = '0; a.z = '0;
		a.stat = plai_pkg::ST_OK;
		case (op)
			plai_pkg::OP_CLEAR: begin
				num_points = 0;
				path_len = 0;
			end
			plai_pkg::OP_APPEND: begin
				if (num_points >= MAX_PTS) begin
					a.stat = plai_pkg::ST_FULL;
				end else begin
					path_x[num_points] = px;
					path_y[num_points] = py;
					path_z[num_points] = pz;
					if (num_points == 0) begin
						cum_len[0] = 0;
					end else begin
						c = cum_len[num_points-1] + planar_length(num_points - 1, num_points);
						cum_len[num_points] = (c > LEN_TOP) ? LEN_TOP : c;
					end
					path_len = cum_len[num_points];
					num_points++;
				end
			end
			plai_pkg::OP_REVERSE: begin
				if (num_points >= 2) begin
					lo = 0;
					hi = num_points - 1;
					while (lo < hi) begin
						t = path_x[lo]; path_x[lo] = path_x[hi]; path_x[hi] = t;
						t = path_y[lo]; path_y[lo] = path_y[hi]; path_y[hi] = t;
						t = path_z[lo]; path_z[lo] = path_z[hi]; path_z[hi] = t;
						lo++;
						hi--;
					end
					acc = 0;
					cum_len[0] = 0;
					for (i = 1; i < num_points; i++) begin
						acc += planar_length(i - 1, i);
						if (acc > LEN_TOP) acc = LEN_TOP;
						cum_len[i] = acc;
					end
					path_len = acc;
				end
			end
			default: begin
				if (num_points == 0) begin
					a.stat = plai_pkg::ST_EMPTY;
				end else begin
					found = 1'b0;
					for (i = 0; i + 1 < num_points && !found; i++) begin
						if (cum_len[i+1] > pos) begin
							seg = cum_len[i+1] - cum_len[i];
							f = ((longint'(pos) - cum_len[i]) <<< 16) / seg;
							if (f > 65535) f = 65535;
							a.x = CB'(blend(path_x[i], path_x[i+1], f));
							a.y = CB'(blend(path_y[i], path_y[i+1], f));
							a.z = CB'(blend(path_z[i], path_z[i+1], f));
							found = 1'b1;
						end
					end
					if (!found) begin
						a.x = CB'(path_x[num_points-1]);
						a.y = CB'(path_y[num_points-1]);
						a.z = CB'(path_z[num_points-1]);
					end
				end
			end
		endcase
		a.total = path_len[27:0];
		a.count = num_points[6:0];
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
		mismatches++;
	endtask

	// Sends one request; the expected result is queued once the request is taken.
	// The request line stays up on return so that requests can follow back to back.
	task automatic send_request(logic [1:0] op, logic signed [CB-1:0] px,
			logic signed [CB-1:0] py, logic signed [CB-1:0] pz, logic [27:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		query_position <= pos;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_answers.push_back(path_update(op, px, py, pz, pos));
		@(negedge clk);
	endtask

	function automatic logic signed [CB-1:0] any_coord();
		return CB'($urandom);
	endfunction

	// Coordinates kept modest so that most queries land inside real segments.
	function automatic logic signed [CB-1:0] near_coord();
		return CB'($signed($urandom_range(4000)) - 2000);
	endfunction

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Result side: pops at random and checks each result against the oldest expectation.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			pop <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			pop <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				$display("result with nothing expected at %0t", $time);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
				if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
				if (total_length !== want.total)
					report_mismatch("total_length", total_length, want.total);
				if (point_count !== want.count)
					report_mismatch("point_count", point_count, want.count);
				if (status !== want.stat) report_mismatch("status", status, want.stat);
			end
		end
	end

	// Directed corners: empty query, full-scale coordinates, single point, ends.
	task automatic test_corners();
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, '0);
		send_request(plai_pkg::OP_REVERSE, '0, '0, '0, '0);
		send_request(plai_pkg::OP_APPEND, 20'sh80000, 20'sh7FFFF, 20'sh80000, '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, LEN_TOP);
		send_request(plai_pkg::OP_REVERSE, '0, '0, '0, '0);
		send_request(plai_pkg::OP_APPEND, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, '0);
		send_request(plai_pkg::OP_APPEND, 20'sh7FFFF, 20'sh80000, 20'sh0, '0);
		send_request(plai_pkg::OP_APPEND, 20'sh0, 20'sh0, 20'sh0, '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'd1000000);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'd30000000);
		send_request(plai_pkg::OP_REVERSE, '0, '0, '0, '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'd20000000);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, LEN_TOP);
		send_request(plai_pkg::OP_CLEAR, '0, '0, '0, '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'd5);
	endtask

	// Fills the path to the limit, then two more appends must be dropped.
	task automatic test_full_path();
		send_request(plai_pkg::OP_CLEAR, '0, '0, '0, '0);
		for (int i = 0; i < MAX_PTS + 2; i++)
			send_request(plai_pkg::OP_APPEND, near_coord(), near_coord(), any_coord(), '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'($urandom_range(60000)));
		send_request(plai_pkg::OP_REVERSE, '0, '0, '0, '0);
		send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'($urandom_range(60000)));
	endtask

	// Random traffic: mostly short well-formed paths queried many times.
	task automatic test_random(int n_items);
		int sent;
		logic [1:0] op;
		sent = 0;
		while (sent < n_items) begin
			op = 2'($urandom_range(3));
			if ($urandom_range(99) < 6) begin
				op = plai_pkg::OP_CLEAR;
			end else if ($urandom_range(99) < 8) begin
				op = plai_pkg::OP_REVERSE;
			end else if (num_points < 2 || $urandom_range(99) < 30) begin
				op = plai_pkg::OP_APPEND;
			end else begin
				op = plai_pkg::OP_QUERY;
			end
			if ($urandom_range(99) < 5)
				op = 2'($urandom_range(3));
			if ($urandom_range(9) == 0)
				send_request(op, any_coord(), any_coord(), any_coord(), 28'($urandom));
			else
				send_request(op, near_coord(), near_coord(), any_coord(),
					($urandom_range(3) == 0) ? 28'($urandom_range(path_len + 40))
						: 28'($urandom_range(path_len)));
			sent++;
		end
	endtask

	// The receiver stops for a long while so the block fills and pushes back.
	task automatic test_back_pressure();
		hold_off_cycles = 600;
		for (int i = 0; i < 8; i++)
			send_request(plai_pkg::OP_QUERY, '0, '0, '0, 28'($urandom_range(path_len)));
		wait_drained();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_corners();
		test_full_path();
		wait_drained();
		test_random(700);
		test_back_pressure();
		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random(300);
		send_idle_pct = 36;
		take_idle_pct = 36;
		test_random(750);
		wait_drained();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
